>>> hw/rtl/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared definitions of the sliding window median filter
// Sizes of the frame store, window limits and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

  localparam int unsigned FrameMax  = 1024;
  localparam int unsigned AddrW     = $clog2(FrameMax);
  localparam int unsigned CntW      = $clog2(FrameMax + 1);
  localparam int unsigned DataW     = 32;
  localparam int unsigned BitW      = $clog2(DataW);
  localparam int unsigned WinW      = 7;
  localparam int unsigned HalfW     = WinW - 1;
  localparam logic [WinW-1:0] WinReset = 7'd41;
  localparam logic [WinW-1:0] WinOne   = 7'd1;

  typedef enum logic [2:0] {
    StIdle,
    StPlan,
    StScan,
    StDecide,
    StEmit
  } state_e;

  // Half width of a window: (w-1)/2 for odd w, w/2-1 for even w.
  function automatic logic [HalfW-1:0] half_width(input logic [WinW-1:0] w);
    logic [HalfW-1:0] h;
    h = w[WinW-1:1];
    if (!w[0]) begin
      h = h - HalfW'(1);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_top: running median over a frame of samples
// Stores a frame in a single-port-write memory and finds each median by a
// bitwise rank search that scans the window once per value bit.
// ----------------------------------------------------------------------------
// Usage: samples enter on the in_valid_i/in_ready_o channel with frame_end_i
// on the last sample of a frame. Medians leave on out_valid_o/out_ready_i
// through an output register, so a waiting result does not block the search
// of the next one. The window size is written through cfg_we_i/cfg_wdata_i
// and is taken at the first sample of each frame; 0 or 1 selects one median
// over the whole frame (even counts average the two middle values).
// One item is worked on at a time. A median search makes one memory read
// per value per bit pass; the whole-frame median of an even count takes
// two such searches. An item that yields no median goes from the plan
// step straight back to idle. At the last sample of a frame all pending
// medians (up to half the window plus one) are produced.
// When the receiver stalls, the sequencer holds in its emit step until the
// output register frees. Reset clears counts and flags and sets the window
// size to 41; the frame memory needs no clearing, since only entries
// written in the current frame are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_filter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swmf_pkg::WinW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [swmf_pkg::DataW-1:0] sample_i,
  input  wire logic                          frame_end_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic signed [swmf_pkg::DataW-1:0] median_o,
  output      logic                          result_last_o,
  output      logic                          overflowed_o
);

  localparam int unsigned CntW  = swmf_pkg::CntW;
  localparam int unsigned AddrW = swmf_pkg::AddrW;
  localparam int unsigned DataW = swmf_pkg::DataW;
  localparam int unsigned BitW  = swmf_pkg::BitW;
  localparam int unsigned WinW  = swmf_pkg::WinW;
  localparam int unsigned HalfW = swmf_pkg::HalfW;
  localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

  swmf_pkg::state_e state_q, state_d;

  logic [WinW-1:0]  win_cfg_q, win_q, win_d;
  logic [CntW-1:0]  cnt_q, cnt_d, next_q, next_d;
  logic             ovf_q, ovf_d, fe_q, fe_d, whole_done_q, whole_done_d;
  logic [CntW-1:0]  lo_q, lo_d, len_q, len_d, rank_q, rank_d, idx_q, idx_d;
  logic [CntW-1:0]  match_q, match_d;
  logic             rd_vld_q, rd_vld_d, second_q, second_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [DataW-1:0] prefix_q, prefix_d, mask_q, mask_d, first_q, first_d;
  logic [DataW-1:0] res_q, res_d;
  logic             out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;
  logic [DataW-1:0] out_med_q, out_med_d;

  logic             accept, whole, mem_we, rd_en, scan_done, want_win, bit_zero;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] rd_data_q, ob, prefix_nx, value;
  logic [HalfW-1:0] half;
  logic [CntW:0]    k_ext;
  logic [CntW-1:0]  lo_w, hi_w, plan_len, rank_nx;
  logic [DataW:0]   pair_sum;

  // Frame memory: one write port for samples, one registered read port.
  logic [DataW-1:0] mem [swmf_pkg::FrameMax];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AddrW-1:0]] <= sample_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Shared decode of the current frame and search.
  assign accept   = in_valid_i && in_ready_o;
  assign whole    = (win_q == swmf_pkg::WinOne);
  assign half     = swmf_pkg::half_width(win_q);
  assign k_ext    = {1'b0, next_q} + (CntW + 1)'(half);
  assign want_win = (next_q < cnt_q) && (fe_q || (k_ext < {1'b0, cnt_q}));
  assign lo_w     = (next_q > CntW'(half)) ? next_q - CntW'(half) : '0;
  assign hi_w     = (k_ext > {1'b0, cnt_q - CntW'(1)}) ? cnt_q - CntW'(1)
                                                       : k_ext[CntW-1:0];
  assign plan_len = whole ? cnt_q : hi_w - lo_w + CntW'(1);
  assign rd_addr  = lo_q[AddrW-1:0] + idx_q[AddrW-1:0];
  assign scan_done = (idx_q == len_q) && !rd_vld_q;
  assign ob        = rd_data_q ^ SignBit;
  assign bit_zero  = rank_q < match_q;
  assign prefix_nx = bit_zero ? prefix_q : prefix_q | (DataW'(1) << bit_q);
  assign rank_nx   = bit_zero ? rank_q : rank_q - match_q;
  assign value     = prefix_nx ^ SignBit;
  assign pair_sum  = {first_q[DataW-1], first_q} + {value[DataW-1], value};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      swmf_pkg::StIdle: begin
        if (accept) state_d = swmf_pkg::StPlan;
      end
      swmf_pkg::StPlan: begin
        if (whole ? (fe_q && !whole_done_q) : want_win) begin
          state_d = swmf_pkg::StScan;
        end else begin
          state_d = swmf_pkg::StIdle;
        end
      end
      swmf_pkg::StScan: begin
        if (scan_done) state_d = swmf_pkg::StDecide;
      end
      swmf_pkg::StDecide: begin
        if (bit_q != '0) begin
          state_d = swmf_pkg::StScan;
        end else if (whole && !cnt_q[0] && !second_q) begin
          state_d = swmf_pkg::StScan;
        end else begin
          state_d = swmf_pkg::StEmit;
        end
      end
      swmf_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) state_d = swmf_pkg::StPlan;
      end
      default: state_d = swmf_pkg::StIdle;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_ready_o = (state_q == swmf_pkg::StIdle);
    mem_we     = accept && (cnt_q != CntW'(swmf_pkg::FrameMax));
    rd_en      = (state_q == swmf_pkg::StScan) && (idx_q != len_q);
  end

  // Datapath and counters.
  always_comb begin
    win_d = win_q;  cnt_d = cnt_q;  next_d = next_q;  ovf_d = ovf_q;
    fe_d = fe_q;  whole_done_d = whole_done_q;  lo_d = lo_q;  len_d = len_q;
    rank_d = rank_q;  idx_d = idx_q;  match_d = match_q;  rd_vld_d = rd_en;
    second_d = second_q;  bit_d = bit_q;  prefix_d = prefix_q;  mask_d = mask_q;
    first_d = first_q;  res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_last_d = out_last_q;  out_ovf_d = out_ovf_q;  out_med_d = out_med_q;
    case (state_q)
      swmf_pkg::StIdle: begin
        if (accept) begin
          if (cnt_q == '0) begin
            win_d = (win_cfg_q == '0) ? swmf_pkg::WinOne : win_cfg_q;
          end
          if (mem_we) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          fe_d = frame_end_i;
          whole_done_d = 1'b0;
        end
      end
      swmf_pkg::StPlan: begin
        // Set up the search of the next median, or close the item.
        lo_d     = whole ? '0 : lo_w;
        len_d    = plan_len;
        rank_d   = (plan_len - CntW'(1)) >> 1;
        idx_d    = '0;
        match_d  = '0;
        bit_d    = BitW'(DataW - 1);
        prefix_d = '0;
        mask_d   = '0;
        second_d = 1'b0;
        if (!(whole ? (fe_q && !whole_done_q) : want_win) && fe_q) begin
          cnt_d = '0;
          next_d = '0;
          ovf_d = 1'b0;
        end
      end
      swmf_pkg::StScan: begin
        // Count values that share the prefix and have a zero at this bit.
        if (rd_en) idx_d = idx_q + CntW'(1);
        if (rd_vld_q && (((ob ^ prefix_q) & mask_q) == '0) && !ob[bit_q]) begin
          match_d = match_q + CntW'(1);
        end
      end
      swmf_pkg::StDecide: begin
        idx_d   = '0;
        match_d = '0;
        if (bit_q != '0) begin
          prefix_d = prefix_nx;
          rank_d   = rank_nx;
          mask_d   = mask_q | (DataW'(1) << bit_q);
          bit_d    = bit_q - BitW'(1);
        end else if (whole && !cnt_q[0] && !second_q) begin
          // Even frame: find the upper middle value next.
          first_d  = value;
          second_d = 1'b1;
          rank_d   = cnt_q >> 1;
          bit_d    = BitW'(DataW - 1);
          prefix_d = '0;
          mask_d   = '0;
        end else begin
          res_d = (whole && !cnt_q[0]) ? pair_sum[DataW:1] : value;
        end
      end
      swmf_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_med_d   = res_q;
          out_ovf_d   = ovf_q;
          out_last_d  = whole || (fe_q && (next_q == cnt_q - CntW'(1)));
          if (whole) begin
            whole_done_d = 1'b1;
          end else begin
            next_d = next_q + CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swmf_pkg::StIdle;
      win_cfg_q    <= swmf_pkg::WinReset;
      win_q        <= swmf_pkg::WinReset;
      cnt_q        <= '0;
      next_q       <= '0;
      ovf_q        <= 1'b0;
      fe_q         <= 1'b0;
      whole_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      second_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) win_cfg_q <= cfg_wdata_i;
      win_q        <= win_d;
      cnt_q        <= cnt_d;
      next_q       <= next_d;
      ovf_q        <= ovf_d;
      fe_q         <= fe_d;
      whole_done_q <= whole_done_d;
      rd_vld_q     <= rd_vld_d;
      second_q     <= second_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Search and output payload registers.
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    len_q     <= len_d;
    rank_q    <= rank_d;
    idx_q     <= idx_d;
    match_q   <= match_d;
    bit_q     <= bit_d;
    prefix_q  <= prefix_d;
    mask_q    <= mask_d;
    first_q   <= first_d;
    res_q     <= res_d;
    out_med_q <= out_med_d;
    out_last_q <= out_last_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign median_o      = out_med_q;
  assign result_last_o = out_last_q;
  assign overflowed_o  = out_ovf_q;

endmodule

`default_nettype wire
